// ===== rtl/ilsm_pkg.sv =====
package ilsm_pkg;

  localparam int unsigned SLOT_COUNT = 2048;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned LINK_W     = 12;

  localparam logic [LINK_W-1:0] NIL = {LINK_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ALLOC       = 2'd0,
    OP_ALLOC_AFTER = 2'd1,
    OP_FREE        = 2'd2,
    OP_READ        = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC1,
    ST_EXEC2,
    ST_EXEC3,
    ST_HOLD
  } state_e;

  typedef struct packed {
    op_e               opcode;
    logic [SLOT_W-1:0] target_slot;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    logic              result_valid;
    logic [LINK_W-1:0] next_link;
    logic [LINK_W-1:0] prev_link;
  } out_t;

  // one write to a link memory, address still a full-width link
  typedef struct packed {
    logic              en;
    logic [LINK_W-1:0] link;
    logic [LINK_W-1:0] data;
  } wr_t;

endpackage

// ===== rtl/indexed_list_slot_manager.sv =====
// channel  direction  handshake               payload
// in       input      in_valid_i / in_ready_o     in_data_i  (in_t: opcode, target_slot)
// out      output     out_valid_o / out_ready_i   out_data_o (out_t: slot, valid, links)
//
// every operation is a transfer step that issues the memory reads,
// then three write steps, bounded by the single write port of the prev memory
// (a free or an allocate-after makes three prev writes in strict order).
// after reset a clearing pass over all SLOT_COUNT (2048) entries loads the initial links;
// in_ready_o stays low during that pass.
// a new operation is taken while the previous result waits on out; if the output
// register is still full when a result is done, the block holds it until out drains.
module indexed_list_slot_manager
  import ilsm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // link usable as an index: not null and inside the table
  function automatic logic usable(input logic [LINK_W-1:0] v);
    return (v != NIL) && (v < LINK_W'(SLOT_COUNT));
  endfunction

  // reset contents: i+1 / i-1, with list ends and heads null
  function automatic logic [LINK_W-1:0] init_next(input logic [SLOT_W-1:0] i);
    if ((i == SLOT_W'(1)) || (i == SLOT_W'(SLOT_COUNT - 1))) begin
      return NIL;
    end
    return {1'b0, i} + LINK_W'(1);
  endfunction

  function automatic logic [LINK_W-1:0] init_prev(input logic [SLOT_W-1:0] i);
    if (i <= SLOT_W'(2)) begin
      return NIL;
    end
    return {1'b0, i} - LINK_W'(1);
  endfunction

  function automatic wr_t mk_wr(input logic en, input logic [LINK_W-1:0] link,
                                input logic [LINK_W-1:0] data);
    wr_t w;
    w.en   = en && usable(link);
    w.link = link;
    w.data = data;
    return w;
  endfunction

  // link memories
  logic [LINK_W-1:0] next_mem [SLOT_COUNT];
  logic [LINK_W-1:0] prev_mem [SLOT_COUNT];

  state_e state_q, state_d;

  logic [SLOT_W-1:0] init_q, init_d;
  logic [LINK_W-1:0] free_head_q, free_head_d;

  // operation context, latched at the input transfer
  op_e               op_q;
  logic [SLOT_W-1:0] tgt_q;
  logic [LINK_W-1:0] head_q;

  // registered read data: next of free head, next and prev of target
  logic [LINK_W-1:0] head_next_q;
  logic [LINK_W-1:0] tgt_next_q;
  logic [LINK_W-1:0] tgt_prev_q;

  out_t res_q, res_d;
  out_t out_data_q;
  logic out_valid_q;

  logic in_fire;
  logic res_load;
  logic out_free;
  logic out_load;
  logic init_last;

  wr_t nwr, pwr;

  logic [LINK_W-1:0] tgt_link;
  logic              head_ok;

  assign tgt_link  = {1'b0, tgt_q};
  assign head_ok   = usable(head_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign init_last = (init_q == SLOT_W'(SLOT_COUNT - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC1;
      end
      ST_EXEC1: state_d = ST_EXEC2;
      ST_EXEC2: state_d = ST_EXEC3;
      ST_EXEC3: begin
        state_d = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o = 1'b0;
    res_load   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_EXEC1: res_load   = 1'b1;
      ST_EXEC3: out_load   = out_free;
      ST_HOLD:  out_load   = out_free;
      default: ;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // write steps: per memory, the writes of one operation go out in order,
  // so an entry hit twice ends with the later value
  always_comb begin
    nwr = '0;
    pwr = '0;
    unique case (state_q)
      ST_INIT: begin
        nwr = mk_wr(1'b1, {1'b0, init_q}, init_next(init_q));
        pwr = mk_wr(1'b1, {1'b0, init_q}, init_prev(init_q));
      end
      ST_EXEC1: begin
        unique case (op_q)
          OP_ALLOC: begin
            pwr = mk_wr(head_ok, head_next_q, NIL);
            nwr = mk_wr(head_ok, head_q, NIL);
          end
          OP_ALLOC_AFTER: begin
            pwr = mk_wr(head_ok, head_next_q, NIL);
            nwr = mk_wr(head_ok, head_q, tgt_next_q);
          end
          OP_FREE: begin
            pwr = mk_wr(1'b1, tgt_next_q, tgt_prev_q);
            nwr = mk_wr(1'b1, tgt_prev_q, tgt_next_q);
          end
          OP_READ: ;
          default: ;
        endcase
      end
      ST_EXEC2: begin
        unique case (op_q)
          OP_ALLOC: begin
            pwr = mk_wr(head_ok, head_q, NIL);
          end
          OP_ALLOC_AFTER: begin
            pwr = mk_wr(head_ok, tgt_next_q, head_q);
            nwr = mk_wr(head_ok, tgt_link, head_q);
          end
          OP_FREE: begin
            pwr = mk_wr(1'b1, head_q, tgt_link);
            nwr = mk_wr(1'b1, tgt_link, head_q);
          end
          OP_READ: ;
          default: ;
        endcase
      end
      ST_EXEC3: begin
        unique case (op_q)
          OP_ALLOC_AFTER: pwr = mk_wr(head_ok, head_q, tgt_link);
          OP_FREE:        pwr = mk_wr(1'b1, tgt_link, NIL);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result and new free head, both known from the read data
  always_comb begin
    res_d       = '{result_slot: '0, result_valid: 1'b0, next_link: NIL, prev_link: NIL};
    free_head_d = free_head_q;
    unique case (op_q)
      OP_ALLOC: begin
        if (head_ok) begin
          res_d.result_slot  = head_q[SLOT_W-1:0];
          res_d.result_valid = 1'b1;
          free_head_d        = head_next_q;
        end
      end
      OP_ALLOC_AFTER: begin
        if (head_ok) begin
          res_d.result_slot  = head_q[SLOT_W-1:0];
          res_d.result_valid = 1'b1;
          // anchor equal to the popped slot leaves it pointing at itself
          res_d.next_link    = (head_q == tgt_link) ? head_q : tgt_next_q;
          res_d.prev_link    = tgt_link;
          free_head_d        = head_next_q;
        end
      end
      OP_FREE: begin
        res_d.result_slot  = tgt_q;
        res_d.result_valid = 1'b1;
        res_d.next_link    = head_q;
        free_head_d        = tgt_link;
      end
      OP_READ: begin
        res_d.result_slot  = tgt_q;
        res_d.result_valid = 1'b1;
        res_d.next_link    = tgt_next_q;
        res_d.prev_link    = tgt_prev_q;
      end
      default: ;
    endcase
  end

  assign init_d = init_q + SLOT_W'(1);

  // memories: reads only in the transfer cycle, so read data holds for the op
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      head_next_q <= next_mem[free_head_q[SLOT_W-1:0]];
      tgt_next_q  <= next_mem[in_data_i.target_slot];
      tgt_prev_q  <= prev_mem[in_data_i.target_slot];
    end
    if (nwr.en) begin
      next_mem[nwr.link[SLOT_W-1:0]] <= nwr.data;
    end
    if (pwr.en) begin
      prev_mem[pwr.link[SLOT_W-1:0]] <= pwr.data;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= in_data_i.opcode;
      tgt_q  <= in_data_i.target_slot;
      head_q <= free_head_q;
    end
    if (res_load) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      free_head_q <= LINK_W'(2);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT) begin
        init_q <= init_d;
      end
      if (res_load) begin
        free_head_q <= free_head_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/ilsm_checker.sv =====
module ilsm_checker
  import ilsm_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one operation in flight
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer while busy");

  // fixed latency into a free output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##4 out_valid_o)
    else $error("result missing four cycles after transfer");

  // failed operation reports slot zero and null links
  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.result_valid |->
      (out_data_o.result_slot == '0) && (out_data_o.next_link == NIL) &&
      (out_data_o.prev_link == NIL))
    else $error("failed result with nonzero fields");

endmodule

bind indexed_list_slot_manager ilsm_checker u_ilsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
